>>> rtl/pser_pkg.sv
// ----------------------------------------------------------------------------
// pser_pkg
// Shared types, widths and helpers for the pattern set exclusivity rate block.
// ----------------------------------------------------------------------------
package pser_pkg;

   localparam int ROW_W        = 32;
   localparam int SET_SIZE_W   = 6;
   localparam int OUT_W        = 17;
   localparam int RATE_FRAC_W  = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

   localparam int DEFAULT_MAX_PATTERNS = 32;
   localparam int DEFAULT_MAX_ROWS     = 65536;

   localparam logic [SET_SIZE_W-1:0] SET_SIZE_RESET = SET_SIZE_W'(2);
   localparam logic [OUT_W-1:0]      RATE_ONE       = OUT_W'(65536);

   typedef struct packed {
      logic [ROW_W-1:0] row_bits;
      logic             last_row;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] rate;
      logic [OUT_W-1:0] covered_rows;
      logic             no_coverage;
   } rsp_type;

   typedef struct packed {
      logic                  covered;
      logic [SET_SIZE_W-1:0] excl_count;
      logic [SET_SIZE_W-1:0] set_size;
      logic                  last_row;
   } row_class_type;

   function automatic logic [SET_SIZE_W-1:0] count_ones32(input logic [ROW_W-1:0] v);
      logic [SET_SIZE_W-1:0] total;
      total = '0;
      for (int k = 0; k < ROW_W / 4; k++) begin
         total = total + SET_SIZE_W'(v[4*k]) + SET_SIZE_W'(v[4*k+1])
                       + SET_SIZE_W'(v[4*k+2]) + SET_SIZE_W'(v[4*k+3]);
      end
      return total;
   endfunction

endpackage

>>> rtl/pser_front.sv
// ----------------------------------------------------------------------------
// pser_front
// Holds the set size register, accepts rows and classifies each one.
// ----------------------------------------------------------------------------
module pser_front
   import pser_pkg::*;
#(
   parameter int MAX_PATTERNS = DEFAULT_MAX_PATTERNS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [SET_SIZE_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  push_valid,
   output row_class_type         push_data,
   input  logic                  push_full
);

   logic [SET_SIZE_W-1:0] selected_count_ff;
   logic [SET_SIZE_W-1:0] selected_count_in;
   logic [SET_SIZE_W-1:0] set_size;
   logic [ROW_W-1:0]      row_mask;
   logic [SET_SIZE_W-1:0] ones;

   always_comb begin
      selected_count_in = csr_write_enable ? csr_write_data : selected_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_count_ff <= SET_SIZE_RESET;
      end else begin
         selected_count_ff <= selected_count_in;
      end
   end

   always_comb begin
      if (int'(selected_count_ff) > MAX_PATTERNS) begin
         set_size = SET_SIZE_W'(MAX_PATTERNS);
      end else begin
         set_size = selected_count_ff;
      end
      for (int i = 0; i < ROW_W; i++) begin
         row_mask[i] = (i < int'(set_size));
      end
      ones = count_ones32(req_data.row_bits & row_mask);
   end

   assign req_stall              = push_full;
   assign push_valid             = req_valid && !push_full;
   assign push_data.covered      = (ones != '0);
   assign push_data.excl_count   = set_size - ones;
   assign push_data.set_size     = set_size;
   assign push_data.last_row     = req_data.last_row;

endmodule

>>> rtl/pser_queue.sv
// ----------------------------------------------------------------------------
// pser_queue
// Short queue of classified rows between the front and the back.
// ----------------------------------------------------------------------------
module pser_queue
   import pser_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  row_class_type push_data,
   output logic          push_full,
   output logic          pop_valid,
   output row_class_type pop_data,
   input  logic          pop_ready
);

   row_class_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff;
   logic [QUEUE_PTR_W:0]   fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_full = (fill_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/pser_back.sv
// ----------------------------------------------------------------------------
// pser_back
// Accumulates classified rows and, after the last row, computes the rate with at most one division per matrix.
// ----------------------------------------------------------------------------
module pser_back
   import pser_pkg::*;
#(
   parameter int MAX_PATTERNS = DEFAULT_MAX_PATTERNS,
   parameter int MAX_ROWS     = DEFAULT_MAX_ROWS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   input  row_class_type pop_data,
   output logic          pop_ready,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam int CNT_W  = $clog2(MAX_ROWS + 1);
   localparam int SUM_W  = $clog2(MAX_ROWS * (MAX_PATTERNS - 1) + 1);
   localparam int DEN_W  = CNT_W + SET_SIZE_W;
   localparam int STEP_W = $clog2(RATE_FRAC_W);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_MUL,
      ST_SETUP,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SET_SIZE_W-1:0]   set_size_ff, set_size_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [RATE_FRAC_W-1:0]  quot_ff, quot_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [OUT_W-1:0]        rate_ff, rate_in;
   logic                    flag_ff, flag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic [DEN_W:0]          rem_dbl;
   logic                    do_pop;

   assign pop_ready = (state_ff == ST_ACCUM);
   assign do_pop    = pop_ready && pop_valid;
   assign rem_dbl   = {rem_ff, 1'b0};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      set_size_in  = set_size_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      rate_in      = rate_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (do_pop) begin
               if (pop_data.covered && (int'(count_ff) < MAX_ROWS)) begin
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + SUM_W'(pop_data.excl_count);
               end
               if (pop_data.last_row) begin
                  set_size_in = pop_data.set_size;
                  state_in    = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            den_in   = DEN_W'(set_size_ff - 1'b1) * DEN_W'(count_ff);
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            rate_in  = '0;
            flag_in  = 1'b0;
            state_in = ST_DONE;
            if (set_size_ff >= SET_SIZE_W'(2)) begin
               if (count_ff == '0) begin
                  flag_in = 1'b1;
               end else if (DEN_W'(sum_ff) >= den_ff) begin
                  rate_in = RATE_ONE;
               end else begin
                  rem_in   = DEN_W'(sum_ff);
                  quot_in  = '0;
                  step_in  = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rem_dbl >= {1'b0, den_ff}) begin
               rem_in  = DEN_W'(rem_dbl - {1'b0, den_ff});
               quot_in = {quot_ff[RATE_FRAC_W-2:0], 1'b1};
            end else begin
               rem_in  = DEN_W'(rem_dbl);
               quot_in = {quot_ff[RATE_FRAC_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(RATE_FRAC_W - 1)) begin
               rate_in  = OUT_W'(quot_in);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.rate         = rate_ff;
               rsp_data_in.covered_rows = OUT_W'(count_ff);
               rsp_data_in.no_coverage  = flag_ff;
               count_in                 = '0;
               sum_in                   = '0;
               state_in                 = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      set_size_ff <= set_size_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      rate_ff     <= rate_in;
      flag_ff     <= flag_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_flag_zero_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.no_coverage && (rsp_data_ff.rate != '0)))
      else $error("no_coverage result carries a nonzero rate");

   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.rate <= RATE_ONE))
      else $error("rate above one");

   a_div_invariant: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ((den_ff != '0) && (rem_ff < den_ff)))
      else $error("divider remainder out of range");
`endif

endmodule

>>> rtl/pattern_set_exclusivity_rate.sv
// ----------------------------------------------------------------------------
// pattern_set_exclusivity_rate
// Throughput: one row per cycle while the accumulator drains the row queue.
// A last row holds the accumulator while a division runs (multiply, check,
// 16 restoring divider steps, result load), or for multiply, check and result
// load without one, plus stalls.
// Reset is synchronous and clears the queue, sums and output; set size is 2.
// ----------------------------------------------------------------------------
module pattern_set_exclusivity_rate
   import pser_pkg::*;
#(
   parameter int MAX_PATTERNS = DEFAULT_MAX_PATTERNS,
   parameter int MAX_ROWS     = DEFAULT_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [SET_SIZE_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   logic          push_valid;
   row_class_type push_data;
   logic          push_full;
   logic          pop_valid;
   row_class_type pop_data;
   logic          pop_ready;

   pser_front #(
      .MAX_PATTERNS(MAX_PATTERNS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .push_valid      (push_valid),
      .push_data       (push_data),
      .push_full       (push_full)
   );

   pser_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_full (push_full),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready)
   );

   pser_back #(
      .MAX_PATTERNS(MAX_PATTERNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_data (pop_data),
      .pop_ready(pop_ready),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
